// ===== rtl/core/vsos_pkg.sv =====
`timescale 1ns / 1ps

package vsos_pkg;

  // History geometry
  localparam int HISTORY_DEPTH = 16;
  localparam int OUTLIER_SPAN  = (HISTORY_DEPTH < 4) ? HISTORY_DEPTH : 4;
  localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
  localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);
  localparam int SH_W          = $clog2(HIST_AW + 1);

  // Field widths
  localparam int IN_W   = 11;
  localparam int VAL_W  = 10;
  localparam int ACC_W  = VAL_W + HIST_AW;
  localparam int RUN_W  = 3;
  localparam int INV_W  = 4;
  localparam int DEC_W  = 5;
  localparam int MARG_W = 6;

  localparam logic [RUN_W-1:0] RUN_FULL = RUN_W'(4);

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 8;

  localparam logic [CFG_AW-1:0] REG_HR_LOWER   = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] REG_HR_UPPER   = CFG_AW'(1);
  localparam logic [CFG_AW-1:0] REG_SPO2_LOWER = CFG_AW'(2);
  localparam logic [CFG_AW-1:0] REG_JUMP       = CFG_AW'(3);
  localparam logic [CFG_AW-1:0] REG_TIMEOUT    = CFG_AW'(4);
  localparam logic [CFG_AW-1:0] REG_DECIMATION = CFG_AW'(5);

  // Reset values
  localparam logic [7:0]        RST_HR_LOWER   = 8'd60;
  localparam logic [7:0]        RST_HR_UPPER   = 8'd150;
  localparam logic [6:0]        RST_SPO2_LOWER = 7'd80;
  localparam logic [MARG_W-1:0] RST_JUMP       = MARG_W'(10);
  localparam logic [INV_W-1:0]  RST_TIMEOUT    = INV_W'(8);
  localparam logic [3:0]        RST_DECIMATION = 4'd8;
  localparam logic [DEC_W-1:0]  RST_DEC_COUNT  = DEC_W'(8);

  // Controller to datapath
  typedef struct packed {
    logic               load;
    logic               eval;
    logic               sum;
    logic               avg;
    logic               emit;
    logic [HIST_AW-1:0] sum_idx;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic go;
  } status_t;

endpackage

// ===== rtl/core/vsos_if.sv =====
`timescale 1ns / 1ps

interface vsos_in_if
  import vsos_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] heart_rate;
  logic                   heart_rate_valid;
  logic signed [IN_W-1:0] oxygen_saturation;
  logic                   oxygen_saturation_valid;

  modport source (
    output valid, heart_rate, heart_rate_valid, oxygen_saturation, oxygen_saturation_valid,
    input  ready
  );
  modport sink (
    input  valid, heart_rate, heart_rate_valid, oxygen_saturation, oxygen_saturation_valid,
    output ready
  );
endinterface

interface vsos_out_if
  import vsos_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             processed;
  logic [VAL_W-1:0] hr_average;
  logic [VAL_W-1:0] spo2_average;

  modport source (
    output valid, processed, hr_average, spo2_average,
    input  ready
  );
  modport sink (
    input  valid, processed, hr_average, spo2_average,
    output ready
  );
endinterface

// ===== rtl/core/vsos_chan.sv =====
`timescale 1ns / 1ps

module vsos_chan
  import vsos_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              upward,
  input  logic              eval,
  input  logic              sum,
  input  logic              avg,
  input  logic [HIST_AW-1:0] sum_idx,
  input  logic              ok,
  input  logic [VAL_W-1:0]  x,
  input  logic [MARG_W-1:0] jump_margin,
  input  logic [INV_W-1:0]  timeout_limit,
  output logic [VAL_W-1:0]  smoothed
);

  logic [VAL_W-1:0]  hist [HISTORY_DEPTH];
  logic [FILL_W-1:0] fill;
  logic [RUN_W-1:0]  run;
  logic [INV_W-1:0]  inval;
  logic [ACC_W-1:0]  acc;
  logic [SH_W-1:0]   sh;
  logic              do_avg;

  logic              outlier;
  logic [FILL_W-1:0] fill_next;
  logic [SH_W-1:0]   sh_next;
  logic [FILL_W-1:0] win;
  logic [HIST_AW-1:0] rd_idx;
  logic              in_win;

  // Check the newest entries against the reading plus or minus the margin
  always_comb begin
    outlier = 1'b1;
    for (int k = HISTORY_DEPTH - OUTLIER_SPAN; k < HISTORY_DEPTH; k++) begin
      if (upward) begin
        if ({1'b0, x} < {1'b0, hist[k]} + (VAL_W+1)'(jump_margin)) outlier = 1'b0;
      end else begin
        if ({1'b0, x} + (VAL_W+1)'(jump_margin) > {1'b0, hist[k]}) outlier = 1'b0;
      end
    end
  end

  // Saturate fill and find the largest power-of-two window within it
  always_comb begin
    fill_next = (fill < FILL_W'(HISTORY_DEPTH)) ? fill + FILL_W'(1) : fill;
    sh_next   = '0;
    for (int i = 0; i < FILL_W; i++) begin
      if (fill_next[i]) sh_next = SH_W'(i);
    end
  end

  // Walk the window from the newest entry backwards
  assign win    = FILL_W'(1) << sh;
  assign rd_idx = HIST_AW'(HISTORY_DEPTH - 1) - sum_idx;
  assign in_win = FILL_W'(sum_idx) < win;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) hist[i] <= '0;
      fill     <= '0;
      run      <= '0;
      inval    <= '0;
      acc      <= '0;
      sh       <= '0;
      do_avg   <= 1'b0;
      smoothed <= '0;
    end else begin
      // Update run, timeout and history for a processed item
      if (eval) begin
        acc    <= '0;
        do_avg <= 1'b0;
        if (!ok) begin
          run <= '0;
          if (inval == timeout_limit) begin
            smoothed <= '0;
            fill     <= '0;
          end else begin
            inval <= inval + INV_W'(1);
          end
        end else begin
          inval <= '0;
          if (run == RUN_FULL && outlier) begin
            run <= '0;
          end else begin
            if (run != RUN_FULL) run <= run + RUN_W'(1);
            for (int i = 0; i < HISTORY_DEPTH - 1; i++) hist[i] <= hist[i+1];
            hist[HISTORY_DEPTH-1] <= x;
            fill <= fill_next;
            sh   <= sh_next;
            if (fill_next < FILL_W'(2)) begin
              smoothed <= x;
            end else begin
              do_avg <= 1'b1;
            end
          end
        end
      end
      // Accumulate one entry a cycle
      if (sum && do_avg && in_win) begin
        acc <= acc + ACC_W'(hist[rd_idx]);
      end
      // Scale the sum down to the mean
      if (avg && do_avg) begin
        smoothed <= VAL_W'(acc >> sh);
      end
    end
  end

endmodule

// ===== rtl/core/vsos_dp.sv =====
`timescale 1ns / 1ps

module vsos_dp
  import vsos_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output status_t                status,
  input  logic                   cfg_we,
  input  logic [CFG_AW-1:0]      cfg_index,
  input  logic [CFG_DW-1:0]      cfg_data,
  input  logic signed [IN_W-1:0] heart_rate,
  input  logic                   heart_rate_valid,
  input  logic signed [IN_W-1:0] oxygen_saturation,
  input  logic                   oxygen_saturation_valid,
  output logic                   processed,
  output logic [VAL_W-1:0]       hr_average,
  output logic [VAL_W-1:0]       spo2_average
);

  logic [7:0]        hr_lower;
  logic [7:0]        hr_upper;
  logic [6:0]        spo2_lower;
  logic [MARG_W-1:0] jump_margin;
  logic [INV_W-1:0]  timeout_limit;
  logic [3:0]        decimation_limit;
  logic [DEC_W-1:0]  dec_count;

  logic signed [IN_W-1:0] hr_q;
  logic signed [IN_W-1:0] sp_q;
  logic                   hr_v;
  logic                   sp_v;
  logic                   go_q;

  logic             go;
  logic             eval_go;
  logic             hr_ok;
  logic             sp_ok;
  logic [VAL_W-1:0] hr_smoothed;
  logic [VAL_W-1:0] sp_smoothed;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hr_lower         <= RST_HR_LOWER;
      hr_upper         <= RST_HR_UPPER;
      spo2_lower       <= RST_SPO2_LOWER;
      jump_margin      <= RST_JUMP;
      timeout_limit    <= RST_TIMEOUT;
      decimation_limit <= RST_DECIMATION;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HR_LOWER:   hr_lower         <= cfg_data;
        REG_HR_UPPER:   hr_upper         <= cfg_data;
        REG_SPO2_LOWER: spo2_lower       <= cfg_data[6:0];
        REG_JUMP:       jump_margin      <= cfg_data[MARG_W-1:0];
        REG_TIMEOUT:    timeout_limit    <= cfg_data[INV_W-1:0];
        REG_DECIMATION: decimation_limit <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Decimate and qualify
  assign go      = dec_count > {1'b0, decimation_limit};
  assign eval_go = cmd.eval && go;
  assign status.go = go;

  assign hr_ok = hr_v && (hr_q < $signed({3'b000, hr_upper}))
                      && (hr_q > $signed({3'b000, hr_lower}));
  assign sp_ok = sp_v && (sp_q > $signed({4'b0000, spo2_lower}));

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_count <= RST_DEC_COUNT;
      go_q      <= 1'b0;
    end else if (cmd.eval) begin
      dec_count <= go ? '0 : dec_count + DEC_W'(1);
      go_q      <= go;
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hr_q <= heart_rate;
      hr_v <= heart_rate_valid;
      sp_q <= oxygen_saturation;
      sp_v <= oxygen_saturation_valid;
    end
  end

  vsos_chan u_hr (
    .clk           (clk),
    .rst           (rst),
    .upward        (1'b1),
    .eval          (eval_go),
    .sum           (cmd.sum),
    .avg           (cmd.avg),
    .sum_idx       (cmd.sum_idx),
    .ok            (hr_ok),
    .x             (hr_q[VAL_W-1:0]),
    .jump_margin   (jump_margin),
    .timeout_limit (timeout_limit),
    .smoothed      (hr_smoothed)
  );

  vsos_chan u_spo2 (
    .clk           (clk),
    .rst           (rst),
    .upward        (1'b0),
    .eval          (eval_go),
    .sum           (cmd.sum),
    .avg           (cmd.avg),
    .sum_idx       (cmd.sum_idx),
    .ok            (sp_ok),
    .x             (sp_q[VAL_W-1:0]),
    .jump_margin   (jump_margin),
    .timeout_limit (timeout_limit),
    .smoothed      (sp_smoothed)
  );

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      processed    <= go_q;
      hr_average   <= hr_smoothed;
      spo2_average <= sp_smoothed;
    end
  end

endmodule

// ===== rtl/core/vsos_ctrl.sv =====
`timescale 1ns / 1ps

module vsos_ctrl
  import vsos_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SUM,
    S_AVG,
    S_EMIT
  } state_t;

  state_t             state;
  logic [HIST_AW-1:0] sum_idx;
  logic               out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Decode commands from the state
  always_comb begin
    cmd.load    = (state == S_IDLE) && in_valid;
    cmd.eval    = (state == S_EVAL);
    cmd.sum     = (state == S_SUM);
    cmd.avg     = (state == S_AVG);
    cmd.emit    = (state == S_EMIT) && out_free;
    cmd.sum_idx = sum_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sum_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop the result once transferred; in S_EMIT a new result takes its place
      if (out_valid && out_ready && state != S_EMIT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EVAL;
        end
        S_EVAL: begin
          sum_idx <= '0;
          state   <= status.go ? S_SUM : S_EMIT;
        end
        S_SUM: begin
          if (sum_idx == HIST_AW'(HISTORY_DEPTH - 1)) begin
            state <= S_AVG;
          end else begin
            sum_idx <= sum_idx + HIST_AW'(1);
          end
        end
        S_AVG: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/vital_sign_outlier_smoother_core.sv =====
`timescale 1ns / 1ps
// A decimated item passes through S_EVAL, S_SUM, S_AVG and S_EMIT; a skipped
// item goes from S_EVAL straight to S_EMIT. The window sum in S_SUM dominates.
// A new item is taken only in S_IDLE; S_EMIT waits until the output register is free.
// Reset (rst, synchronous, active high): registers to defaults, histories, averages and
// counters to zero, decimation counter to eight.
module vital_sign_outlier_smoother_core
  import vsos_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  vsos_in_if.sink           in_ch,
  vsos_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  vsos_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  vsos_dp u_dp (
    .clk                     (clk),
    .rst                     (rst),
    .cmd                     (cmd),
    .status                  (status),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .heart_rate              (in_ch.heart_rate),
    .heart_rate_valid        (in_ch.heart_rate_valid),
    .oxygen_saturation       (in_ch.oxygen_saturation),
    .oxygen_saturation_valid (in_ch.oxygen_saturation_valid),
    .processed               (out_ch.processed),
    .hr_average              (out_ch.hr_average),
    .spo2_average            (out_ch.spo2_average)
  );

endmodule

// ===== tb/vital_sign_outlier_smoother_core_tb.sv =====
`timescale 1ns / 1ps

module vital_sign_outlier_smoother_core_tb;
  import vsos_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 24;
  localparam int PHASE_ITEMS    = 106;

  // Indexes past the last register; writes there must change nothing
  localparam logic [CFG_AW-1:0] REG_SPARE_FIRST = CFG_AW'(6);
  localparam logic [CFG_AW-1:0] REG_SPARE_LAST  = CFG_AW'(7);

  typedef enum int {STALL_NONE, STALL_COIN, STALL_QUARTER, STALL_HEAVY} stall_mode_e;

  typedef struct packed {
    logic [HISTORY_DEPTH-1:0][VAL_W-1:0] hist;
    logic [FILL_W-1:0]                   fill;
    logic [RUN_W-1:0]                    run;
    logic [INV_W-1:0]                    misses;
    logic [VAL_W-1:0]                    avg;
  } chan_t;

  typedef struct packed {
    logic             processed;
    logic [VAL_W-1:0] hr_avg;
    logic [VAL_W-1:0] spo2_avg;
  } vitals_t;

  logic clk;
  logic rst;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  vsos_in_if  in_ch ();
  vsos_out_if out_ch ();

  vital_sign_outlier_smoother_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the register file
  logic [7:0]        cfg_hr_lower;
  logic [7:0]        cfg_hr_upper;
  logic [6:0]        cfg_spo2_lower;
  logic [MARG_W-1:0] cfg_jump;
  logic [INV_W-1:0]  cfg_timeout;
  logic [3:0]        cfg_decim;

  // Predicted block state
  chan_t            hr_chan;
  chan_t            sp_chan;
  logic [DEC_W-1:0] skip_count;

  vitals_t pending_vitals[$];
  int      mismatch_count;
  int      quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // One channel's reaction to a passed reading
  function automatic chan_t advance_channel(input chan_t c, input logic ok, input int x,
                                            input logic upward);
    logic drop;
    int   k;
    int   w;
    int   sh;
    int   acc;
    if (!ok) begin
      c.run = '0;
      if (c.misses == cfg_timeout) begin
        c.avg  = '0;
        c.fill = '0;
      end else begin
        c.misses = c.misses + 1'b1;
      end
      return c;
    end
    c.misses = '0;
    // Outlier screen against the newest entries, only once the run is full
    if (c.run == RUN_FULL) begin
      drop = 1'b1;
      for (k = HISTORY_DEPTH - OUTLIER_SPAN; k < HISTORY_DEPTH; k++) begin
        if (upward ? (x < int'(c.hist[k]) + int'(cfg_jump))
                   : (x > int'(c.hist[k]) - int'(cfg_jump)))
          drop = 1'b0;
      end
      if (drop) begin
        c.run = '0;
        return c;
      end
    end else begin
      c.run = c.run + 1'b1;
    end
    // Shift in, newest at the top index
    for (k = 0; k < HISTORY_DEPTH - 1; k++)
      c.hist[k] = c.hist[k+1];
    c.hist[HISTORY_DEPTH-1] = VAL_W'(x);
    if (c.fill < HISTORY_DEPTH)
      c.fill = c.fill + 1'b1;
    // Power-of-two window over the newest entries
    if (c.fill < 2) begin
      c.avg = VAL_W'(x);
    end else begin
      w  = 1;
      sh = 0;
      while (w * 2 <= c.fill) begin
        w  = w * 2;
        sh = sh + 1;
      end
      acc = 0;
      for (k = HISTORY_DEPTH - w; k < HISTORY_DEPTH; k++)
        acc = acc + int'(c.hist[k]);
      c.avg = VAL_W'(acc >> sh);
    end
    return c;
  endfunction

  // Decimate, qualify and smooth one item; returns the vitals it should report
  function automatic vitals_t smooth_vitals(input logic signed [IN_W-1:0] hr, input logic hr_v,
                                            input logic signed [IN_W-1:0] sp, input logic sp_v);
    vitals_t v;
    logic    go;
    int      hr_i;
    int      sp_i;
    go         = skip_count > cfg_decim;
    skip_count = go ? '0 : skip_count + 1'b1;
    if (go) begin
      hr_i    = hr;
      sp_i    = sp;
      hr_chan = advance_channel(hr_chan,
                  hr_v && hr_i < int'(cfg_hr_upper) && hr_i > int'(cfg_hr_lower), hr_i, 1'b1);
      sp_chan = advance_channel(sp_chan, sp_v && sp_i > int'(cfg_spo2_lower), sp_i, 1'b0);
    end
    v.processed = go;
    v.hr_avg    = hr_chan.avg;
    v.spo2_avg  = sp_chan.avg;
    return v;
  endfunction

  // Present one item and hold it until the transfer
  task automatic send_reading(input logic signed [IN_W-1:0] hr, input logic hr_v,
                              input logic signed [IN_W-1:0] sp, input logic sp_v);
    in_ch.valid                   <= 1'b1;
    in_ch.heart_rate              <= hr;
    in_ch.heart_rate_valid        <= hr_v;
    in_ch.oxygen_saturation       <= sp;
    in_ch.oxygen_saturation_valid <= sp_v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_vitals.push_back(smooth_vitals(hr, hr_v, sp, sp_v));
  endtask

  // Directed reading followed by a random filler that decimation skips
  task automatic send_pair(input int hr, input logic hr_v, input int sp, input logic sp_v);
    send_reading(IN_W'(hr), hr_v, IN_W'(sp), sp_v);
    send_reading(IN_W'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)),
                 IN_W'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)));
  endtask

  // Drop valid and wait until every expected result has arrived
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (pending_vitals.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_HR_LOWER:   cfg_hr_lower   = data[7:0];
      REG_HR_UPPER:   cfg_hr_upper   = data[7:0];
      REG_SPO2_LOWER: cfg_spo2_lower = data[6:0];
      REG_JUMP:       cfg_jump       = data[MARG_W-1:0];
      REG_TIMEOUT:    cfg_timeout    = data[INV_W-1:0];
      REG_DECIMATION: cfg_decim      = data[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Write every register, plus a stray write to an unused index
  task automatic configure(input int hr_lo, input int hr_hi, input int sp_lo, input int jump,
                           input int timeout, input int decim);
    write_reg(REG_HR_LOWER, CFG_DW'(hr_lo));
    write_reg(REG_HR_UPPER, CFG_DW'(hr_hi));
    write_reg(REG_SPO2_LOWER, CFG_DW'(sp_lo));
    write_reg(REG_JUMP, CFG_DW'(jump));
    write_reg(REG_TIMEOUT, CFG_DW'(timeout));
    write_reg(REG_DECIMATION, CFG_DW'(decim));
    write_reg(CFG_AW'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
              CFG_DW'($urandom_range(0, 255)));
    cfg_we <= 1'b0;
  endtask

  // Defaults: the second item is the first one processed
  task automatic test_reset_defaults();
    send_reading(IN_W'(1023), 1'b1, IN_W'(-1024), 1'b1);
    send_reading(IN_W'(70), 1'b1, IN_W'(95), 1'b1);
    send_reading(IN_W'(-1024), 1'b0, IN_W'(1023), 1'b0);
  endtask

  // Range limits on both channels, sign extremes and cleared valid flags
  task automatic test_qualification_bounds();
    wait_for_results();
    configure(RST_HR_LOWER, RST_HR_UPPER, RST_SPO2_LOWER, RST_JUMP, RST_TIMEOUT, 0);
    send_pair(60, 1'b1, 80, 1'b1);
    send_pair(61, 1'b1, 81, 1'b1);
    send_pair(149, 1'b1, 1023, 1'b1);
    send_pair(150, 1'b1, -1024, 1'b1);
    send_pair(100, 1'b0, 90, 1'b0);
    send_pair(-1024, 1'b1, 127, 1'b1);
    send_pair(1023, 1'b1, -1, 1'b1);
  endtask

  // Fill the run, then jump exactly by the margin in each channel's direction
  task automatic test_outlier_rejection();
    int k;
    for (k = 0; k < 4; k++)
      send_pair(100, 1'b1, 95, 1'b1);
    send_pair(100 + RST_JUMP, 1'b1, 95 - RST_JUMP, 1'b1);
  endtask

  // With no tolerance, one invalid reading clears both averages
  task automatic test_timeout_clear();
    wait_for_results();
    configure(RST_HR_LOWER, RST_HR_UPPER, RST_SPO2_LOWER, RST_JUMP, 0, 0);
    send_pair(120, 1'b0, 97, 1'b0);
  endtask

  task automatic random_phase(input int n_items);
    int   sent;
    int   k;
    int   burst_len;
    int   style;
    int   hr_centre;
    int   sp_centre;
    int   hr_i;
    int   sp_i;
    logic hr_v;
    logic sp_v;
    if (cfg_hr_upper > cfg_hr_lower + 1)
      hr_centre = cfg_hr_lower + 1 + $urandom_range(0, cfg_hr_upper - cfg_hr_lower - 2);
    else
      hr_centre = $urandom_range(0, 255);
    if ($urandom_range(0, 3) == 0)
      sp_centre = $urandom_range(cfg_spo2_lower + 1, 1020);
    else
      sp_centre = cfg_spo2_lower + 1 + $urandom_range(0, 40);
    sent = 0;
    while (sent < n_items) begin
      style     = $urandom_range(0, 9);
      burst_len = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
      hr_centre = hr_centre + int'($urandom_range(0, 8)) - 4;
      sp_centre = sp_centre + int'($urandom_range(0, 8)) - 4;
      for (k = 0; k < burst_len && sent < n_items; k++) begin
        if (style < 6) begin
          // Plausible readings around a drifting level, with spikes near the margin
          hr_v = ($urandom_range(0, 24) != 0);
          sp_v = ($urandom_range(0, 24) != 0);
          hr_i = hr_centre + int'($urandom_range(0, 6)) - 3;
          sp_i = sp_centre + int'($urandom_range(0, 6)) - 3;
          if ($urandom_range(0, 5) == 0)
            hr_i = hr_i + int'(cfg_jump) + int'($urandom_range(0, 6)) - 3;
          if ($urandom_range(0, 5) == 0)
            sp_i = sp_i - int'(cfg_jump) - int'($urandom_range(0, 6)) + 3;
        end else if (style < 8) begin
          // Readings that never qualify, to drive the timeout
          hr_v = ($urandom_range(0, 3) == 0);
          sp_v = ($urandom_range(0, 3) == 0);
          hr_i = hr_v ? int'(cfg_hr_upper) + int'($urandom_range(0, 40))
                      : int'($urandom_range(0, 2047));
          sp_i = sp_v ? int'(cfg_spo2_lower) - int'($urandom_range(0, 200))
                      : int'($urandom_range(0, 2047));
        end else begin
          hr_v = 1'($urandom_range(0, 1));
          sp_v = 1'($urandom_range(0, 1));
          hr_i = $urandom_range(0, 2047);
          sp_i = $urandom_range(0, 2047);
        end
        send_reading(IN_W'(hr_i), hr_v, IN_W'(sp_i), sp_v);
        sent = sent + 1;
      end
      // Hold off the sender now and then, sometimes until all results are in
      if ($urandom_range(0, 29) == 0) begin
        wait_for_results();
      end else if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 25)) @(posedge clk);
      end
    end
  endtask

  task automatic test_random_traffic();
    int   p;
    int   lo;
    for (p = 0; p < 8; p++) begin
      wait_for_results();
      lo = $urandom_range(0, 120);
      case (p)
        0: configure(RST_HR_LOWER, RST_HR_UPPER, RST_SPO2_LOWER, RST_JUMP, RST_TIMEOUT,
                     RST_DECIMATION);
        1: configure(0, 255, 0, 0, 0, 0);
        2: configure(255, 0, 127, 63, 15, 0);
        // Timeout lowered below the held count: it wraps before clearing
        3: configure(255, 0, 90, 5, 3, 1);
        4: configure(40, 200, 90, 5, 3, 15);
        default: configure(lo, lo + $urandom_range(20, 135), $urandom_range(0, 127),
                           $urandom_range(0, 20), $urandom_range(0, 15), $urandom_range(0, 3));
      endcase
      random_phase(PHASE_ITEMS);
    end
  endtask

  // Receiver: stall pattern switches to a randomly chosen style at regular intervals
  initial begin
    stall_mode_e mode;
    int          tick;
    out_ch.ready = 1'b0;
    mode         = STALL_NONE;
    tick         = 0;
    forever begin
      @(posedge clk);
      if (tick % 48 == 0)
        mode = stall_mode_e'($urandom_range(0, 3));
      tick = tick + 1;
      case (mode)
        STALL_NONE:    out_ch.ready <= 1'b1;
        STALL_COIN:    out_ch.ready <= 1'($urandom_range(0, 1));
        STALL_QUARTER: out_ch.ready <= (tick % 4 == 0);
        default:       out_ch.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_vitals
    vitals_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_vitals.size() == 0) begin
        $display("%0t: result transfer with nothing expected (processed %0d, hr %0d, spo2 %0d)",
                 $time, out_ch.processed, out_ch.hr_average, out_ch.spo2_average);
        mismatch_count = mismatch_count + 1;
      end else begin
        want = pending_vitals.pop_front();
        if (out_ch.processed !== want.processed) begin
          $display("%0t: processed expected %0d, got %0d", $time, want.processed,
                   out_ch.processed);
          mismatch_count = mismatch_count + 1;
        end
        if (out_ch.hr_average !== want.hr_avg) begin
          $display("%0t: hr_average expected %0d, got %0d", $time, want.hr_avg,
                   out_ch.hr_average);
          mismatch_count = mismatch_count + 1;
        end
        if (out_ch.spo2_average !== want.spo2_avg) begin
          $display("%0t: spo2_average expected %0d, got %0d", $time, want.spo2_avg,
                   out_ch.spo2_average);
          mismatch_count = mismatch_count + 1;
        end
      end
    end
  end

  // Count cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    @(posedge clk);
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("vital_sign_outlier_smoother_core_tb: FAIL");
    $finish;
  end

  initial begin
    rst                           = 1'b1;
    cfg_we                        = 1'b0;
    cfg_index                     = '0;
    cfg_data                      = '0;
    in_ch.valid                   = 1'b0;
    in_ch.heart_rate              = '0;
    in_ch.heart_rate_valid        = 1'b0;
    in_ch.oxygen_saturation       = '0;
    in_ch.oxygen_saturation_valid = 1'b0;
    cfg_hr_lower                  = RST_HR_LOWER;
    cfg_hr_upper                  = RST_HR_UPPER;
    cfg_spo2_lower                = RST_SPO2_LOWER;
    cfg_jump                      = RST_JUMP;
    cfg_timeout                   = RST_TIMEOUT;
    cfg_decim                     = RST_DECIMATION;
    hr_chan                       = '0;
    sp_chan                       = '0;
    skip_count                    = RST_DEC_COUNT;
    mismatch_count                = 0;
    quiet_cycles                  = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_qualification_bounds();
    test_outlier_rejection();
    test_timeout_clear();
    test_random_traffic();

    // Drain, then let the pipeline settle
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("vital_sign_outlier_smoother_core_tb: PASS");
    else
      $display("vital_sign_outlier_smoother_core_tb: FAIL");
    $finish;
  end

endmodule
